[hdl/iat_pkg.sv]
// Shared types and constants for the indexed array table.
package iat_pkg;

   localparam int KIND_W   = 3;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;
   localparam int ADDR_W   = 3;
   localparam int PDATA_W  = 32;

   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SORTED = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

   localparam logic [VALUE_W-1:0] DATA_REJECT = 32'hFFFF_FFFF;
   localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;

   // register word select (paddr bit above the byte offset)
   localparam logic REG_CAPACITY = 1'b0;

   // what each cell computes while the token walks the chain
   typedef enum logic [1:0] {
      SCAN_PICK  = 2'd0,
      SCAN_FIND  = 2'd1,
      SCAN_PLACE = 2'd2
   } scan_mode_type;

   // what each cell does to its entry on the update cycle
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_INS   = 3'd1,
      CELL_DEL   = 3'd2,
      CELL_SET   = 3'd3,
      CELL_SWAP  = 3'd4
   } cell_op_type;

   typedef struct packed {
      scan_mode_type       mode;
      cell_op_type         op;
      logic [VALUE_W-1:0]  value;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_APPLY = 3'b100
   } ctrl_state_type;

endpackage

[hdl/iat_req_if.sv]
// Request channel of the indexed array table.
interface iat_req_if;
   logic                        valid;
   logic                        ready;
   logic [iat_pkg::KIND_W-1:0]  kind;
   logic [iat_pkg::INDEX_W-1:0] index;
   logic [iat_pkg::VALUE_W-1:0] value;

   modport source (output valid, kind, index, value, input ready);
   modport sink   (input valid, kind, index, value, output ready);
endinterface

[hdl/iat_rsp_if.sv]
// Response channel of the indexed array table.
interface iat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [iat_pkg::STATUS_W-1:0] status;
   logic [iat_pkg::VALUE_W-1:0]  data;
   logic [iat_pkg::POS_W-1:0]    position;
   logic [iat_pkg::COUNT_W-1:0]  count;

   modport source (output valid, status, data, position, count, input ready);
   modport sink   (input valid, status, data, position, count, output ready);
endinterface

[hdl/iat_cell.sv]
// One table cell: holds an entry and forwards the scan token to the next cell.
module iat_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  iat_pkg::cell_ctl_type           ctl,
   input  logic [$clog2(DEPTH+1)-1:0]      place,
   input  logic [$clog2(DEPTH+1)-1:0]      pick,
   input  logic [$clog2(DEPTH+1)-1:0]      fill,
   input  logic [iat_pkg::VALUE_W-1:0]     lower_entry,
   input  logic [iat_pkg::VALUE_W-1:0]     upper_entry,
   input  logic [iat_pkg::VALUE_W-1:0]     first_entry,
   input  logic                            tok_found_i,
   input  logic [$clog2(DEPTH+1)-1:0]      tok_pos_i,
   input  logic [iat_pkg::VALUE_W-1:0]     tok_data_i,
   output logic [iat_pkg::VALUE_W-1:0]     entry_o,
   output logic                            tok_found_o,
   output logic [$clog2(DEPTH+1)-1:0]      tok_pos_o,
   output logic [iat_pkg::VALUE_W-1:0]     tok_data_o
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] K      = CW'(INDEX);
   localparam logic [CW-1:0] K_NEXT = CW'(INDEX + 1);
   localparam bit IS_FIRST = (INDEX == 0);
   localparam bit IS_LAST  = (INDEX == DEPTH - 1);

   logic [iat_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                        found_ff, found_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [iat_pkg::VALUE_W-1:0] data_ff, data_in;
   logic                        in_range;

   assign in_range = (K < fill);

   always_comb begin
      found_in = tok_found_i;
      pos_in   = tok_pos_i;
      data_in  = tok_data_i;
      case (ctl.mode)
         iat_pkg::SCAN_FIND: begin
            // first match wins
            if (!tok_found_i && in_range && entry_ff == ctl.value) begin
               found_in = 1'b1;
               pos_in   = K;
            end
         end
         iat_pkg::SCAN_PLACE: begin
            // slot lands just above the highest entry not greater than the value
            if (in_range && ($signed(entry_ff) <= $signed(ctl.value))) begin
               found_in = 1'b1;
               pos_in   = K_NEXT;
            end
         end
         default: begin
            if (K == pick) begin
               data_in = entry_ff;
            end
         end
      endcase
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         iat_pkg::CELL_INS: begin
            if (K == place) begin
               entry_in = ctl.value;
            end else if (!IS_FIRST && K > place) begin
               entry_in = lower_entry;
            end
         end
         iat_pkg::CELL_DEL: begin
            if (!IS_LAST && K >= place) begin
               entry_in = upper_entry;
            end
         end
         iat_pkg::CELL_SET: begin
            if (K == place) begin
               entry_in = ctl.value;
            end
         end
         iat_pkg::CELL_SWAP: begin
            // the found entry equals the searched value
            if (IS_FIRST) begin
               entry_in = ctl.value;
            end else if (K == place) begin
               entry_in = first_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      data_ff  <= data_in;
   end

   assign entry_o     = entry_ff;
   assign tok_found_o = found_ff;
   assign tok_pos_o   = pos_ff;
   assign tok_data_o  = data_ff;

endmodule

[hdl/indexed_array_table_unit.sv]
// Indexed array table top level: control, response register, APB register and cell chain.
// A request is accepted only while idle and is not overlapped with the next one: the scan
// token walks the cell chain in the scan state, then the update state writes the cells
// and the response register, and control returns to idle.
// A pending response does not block the next request; the update waits for a free slot.
// Reset empties the table (count 0) and sets capacity to 16; entries are not cleared.
module indexed_array_table_unit #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   iat_req_if.sink                         req_chan,
   iat_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [iat_pkg::ADDR_W-1:0]      paddr,
   input  logic [iat_pkg::PDATA_W-1:0]     pwdata,
   output logic [iat_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int XW = (CW > iat_pkg::INDEX_W) ? CW : iat_pkg::INDEX_W;
   localparam int SW = $clog2(DEPTH);
   localparam logic [SW-1:0] SCAN_LAST = SW'(DEPTH - 1);
   localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);

   iat_pkg::ctrl_state_type state_ff, state_in;
   logic [SW-1:0]                  scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [iat_pkg::CAP_W-1:0]      capacity_ff, capacity_in;
   logic [iat_pkg::KIND_W-1:0]     kind_ff;
   logic [iat_pkg::INDEX_W-1:0]    index_ff;
   logic [iat_pkg::VALUE_W-1:0]    value_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [iat_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [iat_pkg::VALUE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [iat_pkg::POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [iat_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                           req_accept, slot_free, apply_go, cfg_write;
   logic [XW-1:0]                  n_x, idx_x, cap_x, lim_x;
   logic [CW-1:0]                  place, pick;
   iat_pkg::cell_ctl_type          ctl;
   iat_pkg::cell_op_type           op_sel;
   logic [iat_pkg::STATUS_W-1:0]   status_sel;
   logic [iat_pkg::VALUE_W-1:0]    data_sel;
   logic [iat_pkg::POS_W-1:0]      pos_sel;
   logic [CW-1:0]                  count_sel;

   logic [iat_pkg::VALUE_W-1:0]    entry_w [DEPTH];
   logic                           found_w [DEPTH];
   logic [CW-1:0]                  pos_w   [DEPTH];
   logic [iat_pkg::VALUE_W-1:0]    data_w  [DEPTH];

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == iat_pkg::REG_CAPACITY) ?
                      iat_pkg::PDATA_W'(capacity_ff) : '0;

   always_comb begin
      capacity_in = capacity_ff;
      if (cfg_write && paddr[2] == iat_pkg::REG_CAPACITY) begin
         capacity_in = pwdata[iat_pkg::CAP_W-1:0];
      end
   end

   // ---------------- control ----------------
   assign req_chan.ready = (state_ff == iat_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign apply_go       = (state_ff == iat_pkg::ST_APPLY) && slot_free;

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      unique case (state_ff)
         iat_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in    = iat_pkg::ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         iat_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + SW'(1);
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = iat_pkg::ST_APPLY;
            end
         end
         iat_pkg::ST_APPLY: begin
            if (slot_free) begin
               state_in = iat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iat_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- request decision ----------------
   assign n_x   = XW'(count_ff);
   assign idx_x = XW'(index_ff);
   assign cap_x = XW'(capacity_ff);
   assign lim_x = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;
   assign pick  = CW'(idx_x);

   always_comb begin
      op_sel     = iat_pkg::CELL_HOLD;
      place      = CW'(idx_x);
      status_sel = iat_pkg::STATUS_REJECT;
      data_sel   = '0;
      pos_sel    = '0;
      count_sel  = count_ff;
      unique case (kind_ff)
         iat_pkg::KIND_INSERT: begin
            if (n_x < lim_x && idx_x <= n_x) begin
               op_sel     = iat_pkg::CELL_INS;
               status_sel = iat_pkg::STATUS_DONE;
               count_sel  = count_ff + CW'(1);
            end
         end
         iat_pkg::KIND_DELETE: begin
            if (idx_x < n_x) begin
               op_sel     = iat_pkg::CELL_DEL;
               status_sel = iat_pkg::STATUS_DONE;
               data_sel   = data_w[DEPTH-1];
               count_sel  = count_ff - CW'(1);
            end
         end
         iat_pkg::KIND_SEARCH: begin
            place = pos_w[DEPTH-1];
            if (found_w[DEPTH-1]) begin
               op_sel     = iat_pkg::CELL_SWAP;
               status_sel = iat_pkg::STATUS_DONE;
               pos_sel    = iat_pkg::POS_W'(pos_w[DEPTH-1]);
            end else begin
               status_sel = iat_pkg::STATUS_MISSING;
            end
         end
         iat_pkg::KIND_GET: begin
            if (idx_x < n_x) begin
               status_sel = iat_pkg::STATUS_DONE;
               data_sel   = data_w[DEPTH-1];
            end else begin
               data_sel = iat_pkg::DATA_REJECT;
            end
         end
         iat_pkg::KIND_SET: begin
            if (idx_x < n_x) begin
               op_sel     = iat_pkg::CELL_SET;
               status_sel = iat_pkg::STATUS_DONE;
            end
         end
         iat_pkg::KIND_SORTED: begin
            place = pos_w[DEPTH-1];
            if (n_x < lim_x) begin
               op_sel     = iat_pkg::CELL_INS;
               status_sel = iat_pkg::STATUS_DONE;
               count_sel  = count_ff + CW'(1);
            end
         end
         default: begin
            status_sel = iat_pkg::STATUS_REJECT;
         end
      endcase
   end

   always_comb begin
      ctl.value = value_ff;
      ctl.op    = apply_go ? op_sel : iat_pkg::CELL_HOLD;
      case (kind_ff)
         iat_pkg::KIND_SEARCH: ctl.mode = iat_pkg::SCAN_FIND;
         iat_pkg::KIND_SORTED: ctl.mode = iat_pkg::SCAN_PLACE;
         default:              ctl.mode = iat_pkg::SCAN_PICK;
      endcase
   end

   always_comb begin
      count_in      = apply_go ? count_sel : count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      if (apply_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_sel;
         rsp_data_in   = data_sel;
         rsp_pos_in    = pos_sel;
         rsp_count_in  = iat_pkg::COUNT_W'(count_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iat_pkg::ST_IDLE;
         scan_cnt_ff  <= '0;
         count_ff     <= '0;
         capacity_ff  <= iat_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_chan.kind;
         index_ff <= req_chan.index;
         value_ff <= req_chan.value;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.data     = rsp_data_ff;
   assign rsp_chan.position = rsp_pos_ff;
   assign rsp_chan.count    = rsp_count_ff;

   // ---------------- cell chain ----------------
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [iat_pkg::VALUE_W-1:0] lower_entry, upper_entry;
      logic                        tok_found;
      logic [CW-1:0]               tok_pos;
      logic [iat_pkg::VALUE_W-1:0] tok_data;

      if (g == 0) begin : g_head
         assign lower_entry = entry_w[0];
         assign tok_found   = 1'b0;
         assign tok_pos     = '0;
         assign tok_data    = '0;
      end else begin : g_body
         assign lower_entry = entry_w[g-1];
         assign tok_found   = found_w[g-1];
         assign tok_pos     = pos_w[g-1];
         assign tok_data    = data_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign upper_entry = entry_w[g];
      end else begin : g_mid
         assign upper_entry = entry_w[g+1];
      end

      iat_cell #(
         .DEPTH (DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .place       (place),
         .pick        (pick),
         .fill        (count_ff),
         .lower_entry (lower_entry),
         .upper_entry (upper_entry),
         .first_entry (entry_w[0]),
         .tok_found_i (tok_found),
         .tok_pos_i   (tok_pos),
         .tok_data_i  (tok_data),
         .entry_o     (entry_w[g]),
         .tok_found_o (found_w[g]),
         .tok_pos_o   (pos_w[g]),
         .tok_data_o  (data_w[g])
      );
   end

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == iat_pkg::ST_APPLY))
      else $error("response raised outside update cycle");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != iat_pkg::ST_APPLY) |=> $stable(count_ff))
      else $error("fill count moved outside update cycle");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == iat_pkg::ST_SCAN && scan_cnt_ff == '0))
      else $error("accepted request did not start a scan");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the indexed array table: directed and random requests, stalls.
module tb;

   localparam int DEPTH      = 16;
   localparam int LONG_HOLD  = 400;
   localparam int STALL_STOP = 4000;
   localparam int PHASES     = 7;

   // kinds the block has no operation for
   localparam logic [iat_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [iat_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

   typedef struct packed {
      logic [iat_pkg::KIND_W-1:0]  kind;
      logic [iat_pkg::INDEX_W-1:0] index;
      logic [iat_pkg::VALUE_W-1:0] value;
   } table_request_type;

   typedef struct packed {
      logic [iat_pkg::STATUS_W-1:0] status;
      logic [iat_pkg::VALUE_W-1:0]  data;
      logic [iat_pkg::POS_W-1:0]    position;
      logic [iat_pkg::COUNT_W-1:0]  count;
   } table_answer_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [iat_pkg::ADDR_W-1:0]  paddr;
   logic [iat_pkg::PDATA_W-1:0] pwdata, prdata;

   iat_req_if req_if();
   iat_rsp_if rsp_if();

   indexed_array_table_unit #(.DEPTH(DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // shadow of the table
   logic [iat_pkg::VALUE_W-1:0] shadow_entries [DEPTH];
   int                          shadow_count;
   logic [iat_pkg::CAP_W-1:0]   shadow_capacity;

   table_request_type requests_pending [$];
   table_answer_type  answers_due [$];
   table_request_type next_req;
   table_answer_type  due;

   int  faults;
   int  send_gap, ready_wait;
   int  holds_asked, holds_served;
   int  quiet_cycles;
   int  count_plan;
   bit  send_idling, recv_idling;
   bit  slot_free;

   logic [iat_pkg::CAP_W-1:0] phase_capacity [PHASES];
   int                        phase_items [PHASES];

   // mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [iat_pkg::VALUE_W-1:0] pool_value(int k);
      case (k)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         5: return 32'h0000_0005;
         6: return 32'hFFFF_FFFB;
         default: return 32'h0000_002A;
      endcase
   endfunction

   // applies one request to the shadow table and returns the answer it should give
   function automatic table_answer_type table_step(logic [iat_pkg::KIND_W-1:0] kind,
                                                   logic [iat_pkg::INDEX_W-1:0] index,
                                                   logic [iat_pkg::VALUE_W-1:0] val);
      table_answer_type            ans;
      int                          n, ix, lim, i;
      logic [iat_pkg::VALUE_W-1:0] tmp;
      bit                          hit;
      ans.status   = iat_pkg::STATUS_REJECT;
      ans.data     = '0;
      ans.position = '0;
      n   = shadow_count;
      ix  = int'(index);
      lim = (int'(shadow_capacity) < DEPTH) ? int'(shadow_capacity) : DEPTH;
      hit = 1'b0;
      case (kind)
         iat_pkg::KIND_INSERT: begin
            if (n < lim && ix <= n) begin
               for (i = n; i > ix; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[ix] = val;
               shadow_count = n + 1;
               ans.status = iat_pkg::STATUS_DONE;
            end
         end
         iat_pkg::KIND_DELETE: begin
            if (ix < n) begin
               ans.data = shadow_entries[ix];
               for (i = ix; i + 1 < n; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count = n - 1;
               ans.status = iat_pkg::STATUS_DONE;
            end
         end
         iat_pkg::KIND_SEARCH: begin
            ans.status = iat_pkg::STATUS_MISSING;
            for (i = 0; i < n; i++) begin
               if (!hit && shadow_entries[i] == val) begin
                  hit = 1'b1;
                  tmp = shadow_entries[i];
                  shadow_entries[i] = shadow_entries[0];
                  shadow_entries[0] = tmp;
                  ans.position = iat_pkg::POS_W'(i);
                  ans.status = iat_pkg::STATUS_DONE;
               end
            end
         end
         iat_pkg::KIND_GET: begin
            if (ix < n) begin
               ans.data = shadow_entries[ix];
               ans.status = iat_pkg::STATUS_DONE;
            end else begin
               ans.data = iat_pkg::DATA_REJECT;
            end
         end
         iat_pkg::KIND_SET: begin
            if (ix < n) begin
               shadow_entries[ix] = val;
               ans.status = iat_pkg::STATUS_DONE;
            end
         end
         iat_pkg::KIND_SORTED: begin
            if (n < lim) begin
               i = n;
               while (i > 0 && $signed(shadow_entries[i-1]) > $signed(val)) begin
                  shadow_entries[i] = shadow_entries[i-1];
                  i--;
               end
               shadow_entries[i] = val;
               shadow_count = n + 1;
               ans.status = iat_pkg::STATUS_DONE;
            end
         end
         default: ;
      endcase
      ans.count = iat_pkg::COUNT_W'(shadow_count);
      return ans;
   endfunction

   task automatic push_request(logic [iat_pkg::KIND_W-1:0] kind,
                               logic [iat_pkg::INDEX_W-1:0] index,
                               logic [iat_pkg::VALUE_W-1:0] val);
      table_request_type item;
      item.kind  = kind;
      item.index = index;
      item.value = val;
      requests_pending.push_back(item);
   endtask

   // count_plan follows the fill count so that most indices land in range
   task automatic plan_random_requests(int total);
      table_request_type item;
      int                roll, lim;
      lim = (int'(shadow_capacity) < DEPTH) ? int'(shadow_capacity) : DEPTH;
      for (int k = 0; k < total; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) item.kind = iat_pkg::KIND_INSERT;
         else if (roll < 37) item.kind = iat_pkg::KIND_SORTED;
         else if (roll < 62) item.kind = iat_pkg::KIND_DELETE;
         else if (roll < 76) item.kind = iat_pkg::KIND_SEARCH;
         else if (roll < 86) item.kind = iat_pkg::KIND_GET;
         else if (roll < 96) item.kind = iat_pkg::KIND_SET;
         else item.kind = roll[0] ? KIND_SPARE_A : KIND_SPARE_B;

         if ($urandom_range(0, 99) < 85) begin
            if (item.kind == iat_pkg::KIND_INSERT)
               item.index = iat_pkg::INDEX_W'($urandom_range(0, count_plan));
            else if (count_plan > 0)
               item.index = iat_pkg::INDEX_W'($urandom_range(0, count_plan - 1));
            else item.index = '0;
         end else begin
            item.index = iat_pkg::INDEX_W'($urandom_range(0, 31));
         end

         if ($urandom_range(0, 1) == 0) item.value = pool_value($urandom_range(0, 7));
         else item.value = $urandom;

         if (item.kind == iat_pkg::KIND_INSERT && count_plan < lim
             && int'(item.index) <= count_plan)
            count_plan++;
         else if (item.kind == iat_pkg::KIND_SORTED && count_plan < lim)
            count_plan++;
         else if (item.kind == iat_pkg::KIND_DELETE && int'(item.index) < count_plan)
            count_plan--;
         requests_pending.push_back(item);
      end
   endtask

   task automatic write_capacity(logic [iat_pkg::CAP_W-1:0] cap);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {iat_pkg::REG_CAPACITY, 2'b00};
      pwdata  <= iat_pkg::PDATA_W'(cap);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      shadow_capacity = cap;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (requests_pending.size() != 0 || req_if.valid || answers_due.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            answers_due.push_back(table_step(req_if.kind, req_if.index, req_if.value));
            if (send_idling) send_gap = draw_gap();
         end
         slot_free = !req_if.valid || req_if.ready;
         if (slot_free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
               next_req = requests_pending.pop_front();
               req_if.valid <= 1'b1;
               req_if.kind  <= next_req.kind;
               req_if.index <= next_req.index;
               req_if.value <= next_req.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with random stalls and the occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_wait = 0;
      end else begin
         if (holds_served != holds_asked) begin
            holds_served++;
            ready_wait = LONG_HOLD;
         end
         if (ready_wait > 0) begin
            ready_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (recv_idling && $urandom_range(0, 3) == 0) ready_wait = draw_gap();
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (answers_due.size() == 0) begin
            $error("response with none outstanding: status %0d count %0d",
                   rsp_if.status, rsp_if.count);
            faults++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_if.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_if.status);
               faults++;
            end
            if (rsp_if.data !== due.data) begin
               $error("data: expected %0d, got %0d", $signed(due.data), $signed(rsp_if.data));
               faults++;
            end
            if (rsp_if.position !== due.position) begin
               $error("position: expected %0d, got %0d", due.position, rsp_if.position);
               faults++;
            end
            if (rsp_if.count !== due.count) begin
               $error("count: expected %0d, got %0d", due.count, rsp_if.count);
               faults++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_STOP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind  = '0;
      req_if.index = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      faults       = 0;
      holds_asked  = 0;
      holds_served = 0;
      quiet_cycles = 0;
      send_idling  = 1'b1;
      recv_idling  = 1'b1;
      shadow_count    = 0;
      shadow_capacity = iat_pkg::CAP_RESET;
      phase_capacity = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9, 5'd2, 5'd16};
      phase_items    = '{200, 40, 20, 200, 150, 60, 180};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, full table at a small capacity, extremes, sorted order
      write_capacity(5'd3);
      push_request(iat_pkg::KIND_GET,    5'd0,  32'h0);
      push_request(iat_pkg::KIND_DELETE, 5'd0,  32'h0);
      push_request(iat_pkg::KIND_SEARCH, 5'd0,  32'h0);
      push_request(iat_pkg::KIND_SET,    5'd0,  32'h1);
      push_request(iat_pkg::KIND_INSERT, 5'd1,  32'h1);
      push_request(iat_pkg::KIND_INSERT, 5'd0,  32'h7FFF_FFFF);
      push_request(iat_pkg::KIND_INSERT, 5'd0,  32'h8000_0000);
      push_request(iat_pkg::KIND_INSERT, 5'd2,  32'h0);
      push_request(iat_pkg::KIND_INSERT, 5'd0,  32'h5);
      push_request(iat_pkg::KIND_SORTED, 5'd0,  32'h5);
      push_request(iat_pkg::KIND_SEARCH, 5'd31, 32'h0);
      push_request(iat_pkg::KIND_GET,    5'd2,  32'h0);
      push_request(iat_pkg::KIND_GET,    5'd31, 32'h0);
      push_request(iat_pkg::KIND_SET,    5'd1,  32'hFFFF_FFFF);
      push_request(iat_pkg::KIND_SET,    5'd3,  32'h1);
      push_request(KIND_SPARE_A,         5'd0,  32'hFFFF_FFFF);
      push_request(KIND_SPARE_B,         5'd31, 32'h0);
      push_request(iat_pkg::KIND_DELETE, 5'd2,  32'h0);
      push_request(iat_pkg::KIND_DELETE, 5'd0,  32'h0);
      push_request(iat_pkg::KIND_DELETE, 5'd0,  32'h0);
      push_request(iat_pkg::KIND_DELETE, 5'd31, 32'h0);
      push_request(iat_pkg::KIND_SORTED, 5'd0,  32'h5);
      push_request(iat_pkg::KIND_SORTED, 5'd0,  32'hFFFF_FFFB);
      push_request(iat_pkg::KIND_SORTED, 5'd0,  32'h5);
      push_request(iat_pkg::KIND_SEARCH, 5'd0,  32'h63);
      wait_drained();
      count_plan = shadow_count;

      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_capacity[p]);
         send_idling = (p % 3) != 1;
         recv_idling = (p % 3) != 1;
         // first random phase: receiver holds off so the block backs up
         if (p == 0) holds_asked++;
         plan_random_requests(phase_items[p]);
         wait_drained();
      end

      repeat (DEPTH + 4) @(posedge clock);
      if (faults == 0 && answers_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
